[hdl/fixed_slot_free_list_allocator_unit_assert.svh]
// Assertion macros used by the allocator's checker file.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// Clocked check, masked while rst is high.
`define FSLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define FSLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/fsla_pkg.sv]
// Shared constants, codes and control types of the slot allocator.
`default_nettype none
package fsla_pkg;

  localparam int SLOTS_DEF     = 1024;
  localparam int MAX_SHIFT_DEF = 12;
  localparam int MIN_SHIFT     = 3;

  localparam int OFFSET_W   = 22;
  localparam int COUNT_W    = 11;
  localparam int SHIFT_W    = 4;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int S_TDATA_W  = 24;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 40;
  localparam int M_TUSER_W  = STATUS_W;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd3;
  localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_CORRUPT  = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic cfg_we;      // config write transaction this cycle
    logic clr;         // clearing pass active
    logic accept;      // request transaction this cycle
    logic pop;         // load head from link read data
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic alloc_pop;   // current request is an allocate that succeeds
    logic clr_done;    // clearing pass writes its last entry
    logic out_free;    // output register can take a result
  } sts_t;

endpackage
`default_nettype wire

[hdl/fixed_slot_free_list_allocator_unit.sv]
// Slot pool allocator with a linked free list: top level.
//
// Requests enter on the s_ stream (tuser = op, tdata = free byte offset) and
// each one yields exactly one result on the m_ stream (tuser = status,
// tdata = allocated offset and free slot count). The result is registered
// and shows on m_tvalid in the cycle after the request transaction.
// An allocate that succeeds passes through S_POP, where s_tready is low, since the
// new head comes from a registered read of the link memory at the old head.
// A result waiting on a stalled m_tready holds, and s_tready drops until the
// output register can take the next result; nothing is lost or repeated.
// Reset and every write on the cfg_ channel (index 0 slot_shift, 1
// slot_count) start a clearing pass that rebuilds the list 0, 1, 2 and
// onwards in the link memory; s_tready stays low during it. cfg_ready is
// always high. Write configuration only when no result is outstanding.
`default_nettype none
module fixed_slot_free_list_allocator_unit #(
  parameter int SLOTS     = fsla_pkg::SLOTS_DEF,
  parameter int MAX_SHIFT = fsla_pkg::MAX_SHIFT_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire [fsla_pkg::S_TDATA_W-1:0]     s_tdata,   // [21:0] free_offset
  input  wire [fsla_pkg::S_TUSER_W-1:0]     s_tuser,   // [0] op
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [fsla_pkg::M_TDATA_W-1:0]    m_tdata,   // [21:0] alloc_offset, [32:22] free_slots
  output logic [fsla_pkg::M_TUSER_W-1:0]    m_tuser,   // [1:0] status
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [fsla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [fsla_pkg::COUNT_W-1:0]       cfg_data
);
  import fsla_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  status_t             status;
  logic [OFFSET_W-1:0] alloc_offset;
  logic [COUNT_W-1:0]  free_slots;

  fsla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsla_datapath #(
    .SLOTS     (SLOTS),
    .MAX_SHIFT (MAX_SHIFT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (s_tuser[0]),
    .free_offset  (s_tdata[OFFSET_W-1:0]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .alloc_offset (alloc_offset),
    .free_slots   (free_slots)
  );

  assign m_tdata = {(M_TDATA_W - OFFSET_W - COUNT_W)'(0), free_slots, alloc_offset};
  assign m_tuser = status;

endmodule
`default_nettype wire

[hdl/fsla_ctrl.sv]
// Sequencer of the slot allocator: clearing pass, request intake, head reload.
`default_nettype none
module fsla_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            s_tvalid,
  output logic           s_tready,
  input  wire            cfg_valid,
  output logic           cfg_ready,
  input  fsla_pkg::sts_t sts,
  output fsla_pkg::cmd_t cmd
);
  import fsla_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_POP
  } state_t;

  state_t state;
  logic   cfg_fire;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s_tready  = (state == S_IDLE) && sts.out_free;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    cmd.cfg_we = cfg_fire;
    cmd.clr    = (state == S_CLEAR);
    cmd.accept = accept;
    cmd.pop    = (state == S_POP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else if (cfg_fire) begin
      // any register write rebuilds the pool
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (sts.clr_done) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && sts.alloc_pop) state <= S_POP;
        end
        S_POP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/fsla_datapath.sv]
// Link memory, head and count registers, request checks and result register.
`default_nettype none
module fsla_datapath #(
  parameter int SLOTS     = fsla_pkg::SLOTS_DEF,
  parameter int MAX_SHIFT = fsla_pkg::MAX_SHIFT_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  fsla_pkg::cmd_t                     cmd,
  output fsla_pkg::sts_t                     sts,
  input  wire [fsla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [fsla_pkg::COUNT_W-1:0]        cfg_data,
  input  wire                                op,
  input  wire [fsla_pkg::OFFSET_W-1:0]       free_offset,
  output logic                               out_valid,
  input  wire                                out_ready,
  output fsla_pkg::status_t                  status,
  output logic [fsla_pkg::OFFSET_W-1:0]      alloc_offset,
  output logic [fsla_pkg::COUNT_W-1:0]       free_slots
);
  import fsla_pkg::*;

  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W = $clog2(SLOTS + 1);  // holds the end mark
  localparam int SHW   = $clog2(MAX_SHIFT + 1);
  localparam logic [IDX_W-1:0] END_MARK = IDX_W'(SLOTS);

  logic [IDX_W-1:0]    link_mem [SLOTS];
  logic [IDX_W-1:0]    link_rd;
  logic [SHIFT_W-1:0]  slot_shift;
  logic [COUNT_W-1:0]  slot_count;
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    total;
  logic [AW-1:0]       clr_cnt;

  logic [SHW-1:0]      sh;
  logic [31:0]         n_wide;
  logic [IDX_W-1:0]    n;
  logic [31:0]         clr_next;
  logic [IDX_W-1:0]    clr_val;
  logic [OFFSET_W-1:0] fidx_wide;
  logic [AW-1:0]       fidx;
  logic                misaligned;
  logic                free_ok;
  logic                alloc_ok;
  status_t             res_status;
  logic [OFFSET_W-1:0] res_offset;
  logic [IDX_W-1:0]    total_next;

  // clamp registers to their legal ranges
  always_comb begin
    if (32'(slot_shift) < MIN_SHIFT)      sh = SHW'(MIN_SHIFT);
    else if (32'(slot_shift) > MAX_SHIFT) sh = SHW'(MAX_SHIFT);
    else                                   sh = SHW'(slot_shift);
    if (slot_count == '0)                 n_wide = 32'd1;
    else if (32'(slot_count) > SLOTS)     n_wide = 32'(SLOTS);
    else                                   n_wide = 32'(slot_count);
    n = n_wide[IDX_W-1:0];
  end

  assign clr_next = 32'(clr_cnt) + 32'd1;
  assign clr_val  = (clr_next < 32'(n)) ? IDX_W'(clr_next) : END_MARK;

  assign fidx_wide  = free_offset >> sh;
  assign fidx       = fidx_wide[AW-1:0];
  assign misaligned = |(free_offset & ~({OFFSET_W{1'b1}} << sh));
  assign free_ok    = !misaligned && (32'(fidx_wide) < 32'(n));
  assign alloc_ok   = (total != '0) && (head < n);

  always_comb begin
    res_status = ST_OK;
    res_offset = '0;
    total_next = total;
    if (op == OP_ALLOC) begin
      if (total == '0) begin
        res_status = ST_EMPTY;
      end else if (head >= n) begin
        res_status = ST_CORRUPT;
      end else begin
        res_offset = OFFSET_W'(32'(head) << sh);
        total_next = total - 1'b1;
      end
    end else begin
      if (!free_ok) begin
        res_status = ST_BAD_ADDR;
      end else if (32'(total) < SLOTS) begin
        total_next = total + 1'b1;
      end
    end
  end

  always_comb begin
    sts.alloc_pop = (op == OP_ALLOC) && alloc_ok;
    sts.clr_done  = (32'(clr_cnt) == SLOTS - 1);
    sts.out_free  = !out_valid || out_ready;
  end

  // link memory: clearing pass or free push writes, head entry read
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      link_mem[clr_cnt] <= clr_val;
    end else if (cmd.accept && (op == OP_FREE) && free_ok) begin
      link_mem[fidx] <= head;
    end
    link_rd <= link_mem[head[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_shift <= SHIFT_RST;
      slot_count <= COUNT_RST;
      clr_cnt    <= '0;
      head       <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        clr_cnt <= '0;
        case (cfg_index)
          REG_SLOT_SHIFT: slot_shift <= cfg_data[SHIFT_W-1:0];
          REG_SLOT_COUNT: slot_count <= cfg_data;
          default: ;
        endcase
      end else if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end

      if (cmd.clr) begin
        head  <= '0;
        total <= n;
      end else if (cmd.pop) begin
        head <= link_rd;
      end else if (cmd.accept) begin
        total <= total_next;
        if ((op == OP_FREE) && free_ok) head <= IDX_W'(fidx);
      end

      if (cmd.accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status       <= res_status;
      alloc_offset <= res_offset;
      free_slots   <= COUNT_W'(total_next);
    end
  end

endmodule
`default_nettype wire

[hdl/fsla_checker.sv]
// Port-level checks of the slot allocator, bound to the top level.
`default_nettype none
`include "fixed_slot_free_list_allocator_unit_assert.svh"
module fsla_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               s_tvalid,
  input wire                               s_tready,
  input wire                               m_tvalid,
  input wire                               m_tready,
  input wire [fsla_pkg::M_TDATA_W-1:0]     m_tdata,
  input wire [fsla_pkg::M_TUSER_W-1:0]     m_tuser,
  input wire                               cfg_valid,
  input wire                               cfg_ready
);
  import fsla_pkg::*;

  // a stalled result holds
  `FSLA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // no request transaction unless the output register can take its result
  `FSLA_ASSERT(a_no_overrun, s_tvalid && s_tready |-> !m_tvalid || m_tready, "request taken over a pending result")

  // failed requests return a zero offset
  `FSLA_ASSERT(a_fail_zero, m_tvalid && (m_tuser != ST_OK) |-> m_tdata[OFFSET_W-1:0] == '0, "nonzero offset on failed request")

  // reset and config writes start the clearing pass
  `FSLA_ASSERT_ALWAYS(a_rst_clear, rst |=> !s_tready, "input ready right after reset")
  `FSLA_ASSERT(a_cfg_clear, cfg_valid && cfg_ready |=> !s_tready, "input ready right after config write")

endmodule

bind fixed_slot_free_list_allocator_unit fsla_checker u_fsla_checker (.*);
`default_nettype wire
